// ===== src/pms_pkg.sv =====
// Shared types, constants and helpers for the PWM both-strand scanner.
`default_nettype none
package pms_pkg;

  localparam int MAX_MOTIF_LEN_DEF = 32;
  localparam int WEIGHT_W = 16;
  localparam int SCORE_W = 14;

  localparam logic [5:0] MOTIF_LEN_RESET = 6'd8;

  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [7:0] FOLD_LIMIT = 8'd95;
  localparam logic [7:0] FOLD_OFFSET = 8'd32;
  localparam logic [7:0] GAP_CHAR = 8'h2D;
  localparam logic [7:0] UNKNOWN_CHAR = 8'h4E;
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_T = 2'd1;
  localparam logic [1:0] CODE_C = 2'd2;
  localparam logic [1:0] CODE_G = 2'd3;

  localparam logic [1:0] MASK_COUNT = 2'd3;
  localparam int SCORE_LIMIT = 4096;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] base_char;
    logic [4:0] weight_position;
    logic [1:0] weight_base;
    logic signed [WEIGHT_W-1:0] weight_value;
  } pms_in_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic masked;
  } pms_out_t;

  typedef struct packed {
    logic push;
    logic clear;
    logic load;
    logic shift;
  } pms_cell_ctrl_t;

  typedef struct packed {
    logic ok;
    logic [1:0] code;
  } pms_code_t;

  // Fold lowercase, then map A/T/C/G to a 2-bit code.
  function automatic pms_code_t base_code(input logic [7:0] c);
    logic [7:0] f;
    pms_code_t r;
    f = (c > FOLD_LIMIT) ? c - FOLD_OFFSET : c;
    r.ok = 1'b1;
    r.code = CODE_A;
    case (f)
      CHAR_A: r.code = CODE_A;
      CHAR_T: r.code = CODE_T;
      CHAR_C: r.code = CODE_C;
      CHAR_G: r.code = CODE_G;
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/pms_cell.sv =====
// One window cell: holds a base and a scan copy, both handed along the chain.
`default_nettype none
module pms_cell
  import pms_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire pms_cell_ctrl_t ctrl,
  input  wire logic [7:0]     win_in,
  input  wire logic [7:0]     scan_in,
  output logic [7:0]          win_out,
  output logic [7:0]          scan_out
);

  logic [7:0] win;
  logic [7:0] win_next;
  logic [7:0] scan;

  always_comb begin
    win_next = win;
    if (ctrl.clear) begin
      win_next = 8'd0;
    end else if (ctrl.push) begin
      win_next = win_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= 8'd0;
    end else begin
      win <= win_next;
    end
  end

  // Snapshot the updated window, then walk it toward cell 0.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      scan <= win_next;
    end else if (ctrl.shift) begin
      scan <= scan_in;
    end
  end

  assign win_out = win;
  assign scan_out = scan;

endmodule
`default_nettype wire

// ===== src/pms_wmem.sv =====
// Weight table: one write port, two registered read ports.
`default_nettype none
module pms_wmem
  import pms_pkg::*;
#(
  parameter int AW = 7
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic signed [WEIGHT_W-1:0] wdata,
  input  wire logic [AW-1:0]              raddr_a,
  input  wire logic [AW-1:0]              raddr_b,
  output logic signed [WEIGHT_W-1:0]      rdata_a,
  output logic signed [WEIGHT_W-1:0]      rdata_b
);

  logic signed [WEIGHT_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// ===== src/pwm_motif_score_both_strands.sv =====
// A scoring push presents its result; others give none.
// Throughput: one item per cycle for weight writes, restarts and non-scoring pushes;
//   a scoring push holds off further input through the scan, drain, select and output
//   states, as the scan chain feeds one window position per cycle to the two-port weight
//   table and the previous result still waits on out_ready.
// Reset: rst (synchronous) clears the window, fill count, motif_len to 8 and the
//   output valid; weight entries hold garbage until written.
`default_nettype none
module pwm_motif_score_both_strands
  import pms_pkg::*;
#(
  parameter int MAX_MOTIF_LEN = MAX_MOTIF_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire pms_in_t    in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output pms_out_t        out_data,
  input  wire logic       cfg_we,
  input  wire logic [5:0] cfg_data
);

  localparam int PW = (MAX_MOTIF_LEN > 1) ? $clog2(MAX_MOTIF_LEN) : 1;
  localparam int AW = PW + 2;
  localparam int CW = $clog2(MAX_MOTIF_LEN + 1);
  localparam int SUM_W = WEIGHT_W + PW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_SEL = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0] state;
  logic [5:0] motif_len;
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic [CW-1:0] len_eff;
  logic [PW-1:0] j;
  logic [1:0] bad;
  logic p_f;
  logic p_r;
  logic signed [SUM_W-1:0] fwd_acc;
  logic signed [SUM_W-1:0] rev_acc;
  logic signed [SUM_W-1:0] best;

  logic in_acc;
  logic push_acc;
  logic start;
  logic last;
  pms_cell_ctrl_t ctrl;
  pms_code_t cur;
  logic [7:0] cur_char;
  logic [CW-1:0] pos_f;
  logic [AW-1:0] addr_f;
  logic [AW-1:0] addr_r;
  logic signed [WEIGHT_W-1:0] rd_f;
  logic signed [WEIGHT_W-1:0] rd_r;
  logic wr_en;

  logic [7:0] win_w [MAX_MOTIF_LEN+1];
  logic [7:0] scan_w [MAX_MOTIF_LEN+1];

  // Effective motif length: 0 acts as 1, clamp to the chain length.
  always_comb begin
    if (motif_len == 6'd0) begin
      len_eff = CW'(1);
    end else if ({1'b0, motif_len} > 7'(MAX_MOTIF_LEN)) begin
      len_eff = CW'(MAX_MOTIF_LEN);
    end else begin
      len_eff = CW'(motif_len);
    end
  end

  assign in_ready = (state == S_IDLE);
  assign in_acc = in_valid && in_ready;
  assign push_acc = in_acc && (in_data.action == ACT_PUSH);
  assign fill_next = (fill < CW'(MAX_MOTIF_LEN)) ? fill + CW'(1) : fill;
  assign start = push_acc && (fill_next >= len_eff);
  assign last = (CW'(j) == len_eff - CW'(1));

  always_comb begin
    ctrl.push = push_acc;
    ctrl.clear = in_acc && (in_data.action == ACT_RESTART);
    ctrl.load = start;
    ctrl.shift = (state == S_SCAN);
  end

  assign win_w[0] = in_data.base_char;
  assign scan_w[MAX_MOTIF_LEN] = 8'd0;

  for (genvar k = 0; k < MAX_MOTIF_LEN; k++) begin : g_cell
    pms_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .win_in   (win_w[k]),
      .scan_in  (scan_w[k+1]),
      .win_out  (win_w[k+1]),
      .scan_out (scan_w[k])
    );
  end

  // Position j of the window (newest first) meets forward column len-1-j
  // and reverse column j with the complemented base.
  assign cur_char = scan_w[0];
  assign cur = base_code(cur_char);
  assign pos_f = len_eff - CW'(1) - CW'(j);
  assign addr_f = {pos_f[PW-1:0], cur.code};
  assign addr_r = {j, cur.code ^ 2'b01};

  assign wr_en = in_acc && (in_data.action == ACT_WRITE)
                 && ({2'b00, in_data.weight_position} < 7'(MAX_MOTIF_LEN));

  pms_wmem #(
    .AW (AW)
  ) u_wmem (
    .clk     (clk),
    .we      (wr_en),
    .waddr   ({PW'(in_data.weight_position), in_data.weight_base}),
    .wdata   (in_data.weight_value),
    .raddr_a (addr_f),
    .raddr_b (addr_r),
    .rdata_a (rd_f),
    .rdata_b (rd_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      motif_len <= MOTIF_LEN_RESET;
    end else if (cfg_we) begin
      motif_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctrl.clear) begin
      fill <= '0;
    end else if (push_acc) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      p_f <= 1'b0;
      p_r <= 1'b0;
    end else begin
      p_f <= (state == S_SCAN) && cur.ok;
      p_r <= (state == S_SCAN) && cur.ok;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_SEL;
        S_SEL: state <= S_OUT;
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Raise valid when a new result is loaded, drop it once the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Datapath: scan index, gap and unknown-base count, strand sums, final select.
  always_ff @(posedge clk) begin
    if (start) begin
      j <= '0;
      bad <= 2'd0;
      fwd_acc <= '0;
      rev_acc <= '0;
    end else begin
      if (state == S_SCAN) begin
        j <= j + PW'(1);
        if ((cur_char == GAP_CHAR || cur_char == UNKNOWN_CHAR) && bad != MASK_COUNT) begin
          bad <= bad + 2'd1;
        end
      end
      if (p_f) begin
        fwd_acc <= fwd_acc + SUM_W'(rd_f);
      end
      if (p_r) begin
        rev_acc <= rev_acc + SUM_W'(rd_r);
      end
    end
    if (state == S_SEL) begin
      best <= (rev_acc > fwd_acc) ? rev_acc : fwd_acc;
    end
  end

  logic [SUM_W-1:0] mag;
  logic [SUM_W-1:0] q;
  logic [SUM_W-1:0] q_sat;
  logic signed [SCORE_W-1:0] score_c;

  // Truncate toward zero, then saturate the magnitude.
  always_comb begin
    mag = best[SUM_W-1] ? SUM_W'(-best) : SUM_W'(best);
    q = mag >> 8;
    q_sat = (q > SUM_W'(SCORE_LIMIT)) ? SUM_W'(SCORE_LIMIT) : q;
    score_c = best[SUM_W-1] ? -SCORE_W'(q_sat) : SCORE_W'(q_sat);
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ready)) begin
      out_data.masked <= (bad == MASK_COUNT);
      out_data.score <= (bad == MASK_COUNT) ? '0 : score_c;
    end
  end

endmodule
`default_nettype wire
